>>> src/mutex_cond_barrier_sync_engine_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion wrappers for the synchronization engine; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef MUTEX_COND_BARRIER_SYNC_ENGINE_MACROS_SVH
`define MUTEX_COND_BARRIER_SYNC_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MCBSE_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("mcbse assertion failed");
// next-cycle implication
`define MCBSE_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("mcbse assertion failed");
`else
`define MCBSE_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define MCBSE_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif

`endif

>>> src/mcbse_pkg.sv
// ---------------------------------------------------------------------------
// mcbse_pkg
// Types, sizes and codes shared by the synchronization engine modules.
// ---------------------------------------------------------------------------
package mcbse_pkg;

  // table sizes
  localparam int NUM_CORES    = 32;
  localparam int MAX_MUTEXES  = 64;
  localparam int MAX_CONDS    = 64;
  localparam int MAX_BARRIERS = 16;

  // request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // special link and holder values
  localparam logic [5:0] HOLDER_NONE = 6'd32;
  localparam logic [5:0] LINK_NONE   = 6'd63;

  // operation codes
  localparam logic [3:0] OP_MUTEX_INIT   = 4'd0;
  localparam logic [3:0] OP_LOCK         = 4'd1;
  localparam logic [3:0] OP_UNLOCK       = 4'd2;
  localparam logic [3:0] OP_COND_INIT    = 4'd3;
  localparam logic [3:0] OP_COND_WAIT    = 4'd4;
  localparam logic [3:0] OP_SIGNAL       = 4'd5;
  localparam logic [3:0] OP_BROADCAST    = 4'd6;
  localparam logic [3:0] OP_BARRIER_INIT = 4'd7;
  localparam logic [3:0] OP_BARRIER_WAIT = 4'd8;

  // reply kinds
  localparam logic [2:0] K_INDEX   = 3'd0;
  localparam logic [2:0] K_GRANT   = 3'd1;
  localparam logic [2:0] K_UNLOCK  = 3'd2;
  localparam logic [2:0] K_SIGNAL  = 3'd3;
  localparam logic [2:0] K_BCAST   = 3'd4;
  localparam logic [2:0] K_RELEASE = 3'd5;
  localparam logic [2:0] K_ERROR   = 3'd6;

  // one classified request
  typedef struct packed {
    logic [3:0]  op;
    logic [4:0]  req;
    logic [63:0] stamp;
    logic [5:0]  mi;
    logic [5:0]  ci;
    logic [3:0]  bi;
    logic [5:0]  bsize;
    logic        pre_err;
  } item_t;

  // mutex table row
  typedef struct packed {
    logic [5:0] holder;
    logic [5:0] head;
    logic [4:0] tail;
  } mrow_t;

  // condition table row
  typedef struct packed {
    logic [5:0] head;
    logic [4:0] tail;
  } crow_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic idle;
  } back_status_t;

endpackage

>>> src/mcbse_front.sv
// ---------------------------------------------------------------------------
// mcbse_front
// Accepts request beats, flags requests that are malformed on their face
// and pushes them into the request queue.
// ---------------------------------------------------------------------------
module mcbse_front (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [3:0]            in_operation,
  input  logic [4:0]            in_requester,
  input  logic [63:0]           in_request_time,
  input  logic [5:0]            in_mutex_index,
  input  logic [5:0]            in_cond_index,
  input  logic [3:0]            in_barrier_index,
  input  logic [5:0]            in_barrier_size,
  input  mcbse_pkg::q_status_t  q_stat,
  output logic                  q_push,
  output mcbse_pkg::item_t      q_item
);
  import mcbse_pkg::*;

  // hold off while the queue is full
  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  // classify and pack
  always_comb begin
    q_item.op      = in_operation;
    q_item.req     = in_requester;
    q_item.stamp   = in_request_time;
    q_item.mi      = in_mutex_index;
    q_item.ci      = in_cond_index;
    q_item.bi      = in_barrier_index;
    q_item.bsize   = in_barrier_size;
    q_item.pre_err = (in_operation > OP_BARRIER_WAIT) ||
                     ({1'b0, in_requester} >= 6'(NUM_CORES));
  end

endmodule

>>> src/mcbse_queue.sv
// ---------------------------------------------------------------------------
// mcbse_queue
// Short request queue that decouples the front from the back.
// ---------------------------------------------------------------------------
module mcbse_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mcbse_pkg::item_t      din,
  input  logic                  pop,
  output mcbse_pkg::item_t      dout,
  output mcbse_pkg::q_status_t  stat
);
  import mcbse_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout       = mem_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == (QAW+1)'(QDEPTH));

endmodule

>>> src/mcbse_back.sv
// ---------------------------------------------------------------------------
// mcbse_back
// Executes queued requests against the lock, condition and barrier tables
// and sends replies through a single output register.
// ---------------------------------------------------------------------------
module mcbse_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mcbse_pkg::item_t         q_item,
  input  mcbse_pkg::q_status_t     q_stat,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [4:0]               out_dest_core,
  output logic [2:0]               out_reply_kind,
  output logic [5:0]               out_reply_value,
  output logic [63:0]              out_reply_time,
  output logic                     out_last,
  output mcbse_pkg::back_status_t  b_stat
);
  import mcbse_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SECOND = 3'd2;
  localparam logic [2:0] S_WRD    = 3'd3;
  localparam logic [2:0] S_WAKE   = 3'd4;
  localparam logic [2:0] S_BREL   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  item_t       work_r, work_nxt;
  logic [6:0]  mused_r, mused_nxt;
  logic [6:0]  cused_r, cused_nxt;
  logic [4:0]  bused_r, bused_nxt;
  logic [5:0]  cur_r, cur_nxt;
  logic [4:0]  wc_r, wc_nxt;
  logic [63:0] rel_time_r, rel_time_nxt;
  logic [2:0]  second_kind_r, second_kind_nxt;
  logic [NUM_CORES-1:0] waiting_r, waiting_nxt;

  // per-core and per-barrier tables
  logic [5:0]  link_r   [NUM_CORES];
  logic [5:0]  reacq_r  [NUM_CORES];
  logic [5:0]  b_need_r [MAX_BARRIERS];
  logic [5:0]  b_arr_r  [MAX_BARRIERS];
  logic [5:0]  b_head_r [MAX_BARRIERS];
  logic [4:0]  b_tail_r [MAX_BARRIERS];
  logic [63:0] b_time_r [MAX_BARRIERS];

  // mutex and condition memories
  mrow_t mtab [MAX_MUTEXES];
  crow_t ctab [MAX_CONDS];
  mrow_t mrd_r, mwd;
  crow_t crd_r, cwd;
  logic [5:0] mrd_addr, mwa, crd_addr, cwa;
  logic       mwe, cwe;

  // side-effect controls
  logic       lwe0, lwe1;
  logic [4:0] lwa0, lwa1;
  logic [5:0] lwd0, lwd1;
  logic       wset_e, wclr_e;
  logic [4:0] wset_a, wclr_a;
  logic       rqe, b_init_e, b_upd_e;
  logic [5:0] b_arr_w, b_head_w;
  logic [4:0] b_tail_w;
  logic [63:0] b_time_w;

  // reply register
  logic        out_valid_r;
  logic [4:0]  out_dest_r;
  logic [2:0]  out_kind_r;
  logic [5:0]  out_value_r;
  logic [63:0] out_time_r;
  logic        out_last_r;
  logic        em_e, em_last;
  logic [4:0]  em_dest;
  logic [2:0]  em_kind;
  logic [5:0]  em_val;
  logic [63:0] em_time;
  logic        out_free;

  // working values
  logic [5:0]  req6, wake_m, b_arr1, first_c;
  logic [5:0]  b_need, b_arr, b_head;
  logic [4:0]  b_tail;
  logic [63:0] b_time;
  logic        bad;

  assign out_free = !out_valid_r || !out_stall;
  assign req6     = {1'b0, work_r.req};
  assign wake_m   = reacq_r[wc_r];
  assign b_need   = b_need_r[work_r.bi];
  assign b_arr    = b_arr_r[work_r.bi];
  assign b_head   = b_head_r[work_r.bi];
  assign b_tail   = b_tail_r[work_r.bi];
  assign b_time   = b_time_r[work_r.bi];
  assign b_arr1   = b_arr + 6'd1;
  assign first_c  = (b_head == LINK_NONE) ? req6 : b_head;

  // request checks
  always_comb begin
    bad = work_r.pre_err || waiting_r[work_r.req];
    case (work_r.op)
      OP_MUTEX_INIT:   bad = bad || (mused_r >= 7'(MAX_MUTEXES));
      OP_LOCK:         bad = bad || ({1'b0, work_r.mi} >= mused_r);
      OP_UNLOCK:       bad = bad || ({1'b0, work_r.mi} >= mused_r) ||
                             (mrd_r.holder != req6);
      OP_COND_INIT:    bad = bad || (cused_r >= 7'(MAX_CONDS));
      OP_COND_WAIT:    bad = bad || ({1'b0, work_r.mi} >= mused_r) ||
                             ({1'b0, work_r.ci} >= cused_r) ||
                             (mrd_r.holder != req6);
      OP_SIGNAL:       bad = bad || ({1'b0, work_r.ci} >= cused_r);
      OP_BROADCAST:    bad = bad || ({1'b0, work_r.ci} >= cused_r);
      OP_BARRIER_INIT: bad = bad || (bused_r >= 5'(MAX_BARRIERS));
      OP_BARRIER_WAIT: bad = bad || ({1'b0, work_r.bi} >= bused_r) ||
                             (({1'b0, b_arr} + 7'd1) > {1'b0, b_need});
      default:         bad = 1'b1;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    work_nxt        = work_r;
    mused_nxt       = mused_r;
    cused_nxt       = cused_r;
    bused_nxt       = bused_r;
    cur_nxt         = cur_r;
    wc_nxt          = wc_r;
    rel_time_nxt    = rel_time_r;
    second_kind_nxt = second_kind_r;
    q_pop    = 1'b0;
    mwe      = 1'b0;
    mwa      = work_r.mi;
    mwd      = mrd_r;
    cwe      = 1'b0;
    cwa      = work_r.ci;
    cwd      = crd_r;
    lwe0     = 1'b0;
    lwa0     = work_r.req;
    lwd0     = LINK_NONE;
    lwe1     = 1'b0;
    lwa1     = mrd_r.tail;
    lwd1     = req6;
    wset_e   = 1'b0;
    wset_a   = work_r.req;
    wclr_e   = 1'b0;
    wclr_a   = mrd_r.head[4:0];
    rqe      = 1'b0;
    b_init_e = 1'b0;
    b_upd_e  = 1'b0;
    b_arr_w  = b_arr1;
    b_head_w = b_head;
    b_tail_w = work_r.req;
    b_time_w = b_time;
    em_e     = 1'b0;
    em_dest  = work_r.req;
    em_kind  = K_ERROR;
    em_val   = 6'd0;
    em_time  = work_r.stamp;
    em_last  = 1'b1;
    mrd_addr = work_r.mi;
    crd_addr = work_r.ci;

    case (state_r)
      // take the next request and start the table reads
      S_IDLE: begin
        mrd_addr = q_item.mi;
        crd_addr = q_item.ci;
        if (!q_stat.empty) begin
          q_pop     = 1'b1;
          work_nxt  = q_item;
          state_nxt = S_EXEC;
        end
      end

      // carry out the request with the table rows in hand
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          if (bad) begin
            em_e = 1'b1;
          end else begin
            case (work_r.op)
              OP_MUTEX_INIT: begin
                mwe       = 1'b1;
                mwa       = mused_r[5:0];
                mwd       = '{holder: HOLDER_NONE, head: LINK_NONE, tail: 5'd0};
                mused_nxt = mused_r + 7'd1;
                em_e      = 1'b1;
                em_kind   = K_INDEX;
                em_val    = mused_r[5:0];
              end
              OP_LOCK: begin
                mwe = 1'b1;
                if (mrd_r.holder == HOLDER_NONE) begin
                  mwd.holder = req6;
                  em_e       = 1'b1;
                  em_kind    = K_GRANT;
                end else begin
                  lwe0   = 1'b1;
                  wset_e = 1'b1;
                  if (mrd_r.head == LINK_NONE) begin
                    mwd.head = req6;
                  end else begin
                    lwe1 = 1'b1;
                  end
                  mwd.tail = work_r.req;
                end
              end
              OP_UNLOCK: begin
                mwe = 1'b1;
                em_e = 1'b1;
                if (mrd_r.head == LINK_NONE) begin
                  mwd.holder = HOLDER_NONE;
                  em_kind    = K_UNLOCK;
                end else begin
                  mwd.holder      = mrd_r.head;
                  mwd.head        = link_r[mrd_r.head[4:0]];
                  wclr_e          = 1'b1;
                  em_dest         = mrd_r.head[4:0];
                  em_kind         = K_GRANT;
                  em_last         = 1'b0;
                  second_kind_nxt = K_UNLOCK;
                  state_nxt       = S_SECOND;
                end
              end
              OP_COND_INIT: begin
                cwe       = 1'b1;
                cwa       = cused_r[5:0];
                cwd       = '{head: LINK_NONE, tail: 5'd0};
                cused_nxt = cused_r + 7'd1;
                em_e      = 1'b1;
                em_kind   = K_INDEX;
                em_val    = cused_r[5:0];
              end
              OP_COND_WAIT: begin
                // park on the condition
                rqe    = 1'b1;
                cwe    = 1'b1;
                lwe0   = 1'b1;
                wset_e = 1'b1;
                if (crd_r.head == LINK_NONE) begin
                  cwd.head = req6;
                end else begin
                  lwe1 = 1'b1;
                  lwa1 = crd_r.tail;
                end
                cwd.tail = work_r.req;
                // and let go of the mutex
                mwe = 1'b1;
                if (mrd_r.head == LINK_NONE) begin
                  mwd.holder = HOLDER_NONE;
                end else begin
                  mwd.holder = mrd_r.head;
                  mwd.head   = link_r[mrd_r.head[4:0]];
                  wclr_e     = 1'b1;
                  em_e       = 1'b1;
                  em_dest    = mrd_r.head[4:0];
                  em_kind    = K_GRANT;
                end
              end
              OP_SIGNAL: begin
                if (crd_r.head == LINK_NONE) begin
                  em_e    = 1'b1;
                  em_kind = K_SIGNAL;
                end else begin
                  cwe       = 1'b1;
                  cwd.head  = link_r[crd_r.head[4:0]];
                  wc_nxt    = crd_r.head[4:0];
                  state_nxt = S_WRD;
                end
              end
              OP_BROADCAST: begin
                if (crd_r.head == LINK_NONE) begin
                  em_e    = 1'b1;
                  em_kind = K_BCAST;
                end else begin
                  wc_nxt    = crd_r.head[4:0];
                  cur_nxt   = link_r[crd_r.head[4:0]];
                  state_nxt = S_WRD;
                end
              end
              OP_BARRIER_INIT: begin
                b_init_e  = 1'b1;
                bused_nxt = bused_r + 5'd1;
                em_e      = 1'b1;
                em_kind   = K_INDEX;
                em_val    = {1'b0, bused_r};
              end
              OP_BARRIER_WAIT: begin
                b_upd_e = 1'b1;
                lwe0    = 1'b1;
                wset_e  = 1'b1;
                if (b_head == LINK_NONE) begin
                  b_head_w = req6;
                end else begin
                  lwe1 = 1'b1;
                  lwa1 = b_tail;
                end
                if ((b_arr1 == 6'd1) || (work_r.stamp > b_time)) begin
                  b_time_w = work_r.stamp;
                end
                // last arrival: release everyone in order
                if (b_arr1 == b_need) begin
                  b_arr_w      = 6'd0;
                  b_head_w     = LINK_NONE;
                  cur_nxt      = first_c;
                  rel_time_nxt = b_time_w;
                  state_nxt    = S_BREL;
                end
              end
              default: begin
                em_e = 1'b1;
              end
            endcase
          end
        end
      end

      // fetch the mutex row of the woken waiter
      S_WRD: begin
        mrd_addr  = wake_m;
        state_nxt = S_WAKE;
      end

      // woken waiter takes its mutex or queues on it
      S_WAKE: begin
        mrd_addr = wake_m;
        if (out_free) begin
          wclr_e = 1'b1;
          wclr_a = wc_r;
          if ({1'b0, wake_m} < 7'(MAX_MUTEXES)) begin
            mwe = 1'b1;
            mwa = wake_m;
            if (mrd_r.holder == HOLDER_NONE) begin
              mwd.holder = {1'b0, wc_r};
              em_e       = 1'b1;
              em_dest    = wc_r;
              em_kind    = K_GRANT;
              em_last    = 1'b0;
            end else begin
              lwe0   = 1'b1;
              lwa0   = wc_r;
              wset_e = 1'b1;
              wset_a = wc_r;
              if (mrd_r.head == LINK_NONE) begin
                mwd.head = {1'b0, wc_r};
              end else begin
                lwe1 = 1'b1;
                lwd1 = {1'b0, wc_r};
              end
              mwd.tail = wc_r;
            end
          end
          if (work_r.op == OP_SIGNAL) begin
            second_kind_nxt = K_SIGNAL;
            state_nxt       = S_SECOND;
          end else if (cur_r == LINK_NONE) begin
            cwe             = 1'b1;
            cwd.head        = LINK_NONE;
            second_kind_nxt = K_BCAST;
            state_nxt       = S_SECOND;
          end else begin
            wc_nxt    = cur_r[4:0];
            cur_nxt   = link_r[cur_r[4:0]];
            state_nxt = S_WRD;
          end
        end
      end

      // closing reply to the requester
      S_SECOND: begin
        if (out_free) begin
          em_e      = 1'b1;
          em_kind   = second_kind_r;
          state_nxt = S_IDLE;
        end
      end

      // one barrier release per cycle while the receiver does not stall
      S_BREL: begin
        if (out_free) begin
          wclr_e  = 1'b1;
          wclr_a  = cur_r[4:0];
          em_e    = 1'b1;
          em_dest = cur_r[4:0];
          em_kind = K_RELEASE;
          em_time = rel_time_r;
          em_last = (link_r[cur_r[4:0]] == LINK_NONE);
          cur_nxt = link_r[cur_r[4:0]];
          if (em_last) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // waiting flags: a woken core that queues again stays set
  always_comb begin
    waiting_nxt = waiting_r;
    if (wclr_e) begin
      waiting_nxt[wclr_a] = 1'b0;
    end
    if (wset_e) begin
      waiting_nxt[wset_a] = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mused_r     <= '0;
      cused_r     <= '0;
      bused_r     <= '0;
      waiting_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      mused_r   <= mused_nxt;
      cused_r   <= cused_nxt;
      bused_r   <= bused_nxt;
      waiting_r <= waiting_nxt;
      if (em_e) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers and reply payload
  always_ff @(posedge clk) begin
    work_r        <= work_nxt;
    cur_r         <= cur_nxt;
    wc_r          <= wc_nxt;
    rel_time_r    <= rel_time_nxt;
    second_kind_r <= second_kind_nxt;
    if (em_e) begin
      out_dest_r  <= em_dest;
      out_kind_r  <= em_kind;
      out_value_r <= em_val;
      out_time_r  <= em_time;
      out_last_r  <= em_last;
    end
  end

  // link, reacquire and barrier tables
  always_ff @(posedge clk) begin
    // tail link update wins over the new waiter's own link
    for (int i = 0; i < NUM_CORES; i++) begin
      if (lwe1 && (lwa1 == 5'(i))) begin
        link_r[i] <= lwd1;
      end else if (lwe0 && (lwa0 == 5'(i))) begin
        link_r[i] <= lwd0;
      end
    end
    if (rqe) begin
      reacq_r[work_r.req] <= work_r.mi;
    end
    if (b_init_e) begin
      b_need_r[bused_r[3:0]] <= work_r.bsize;
      b_arr_r[bused_r[3:0]]  <= 6'd0;
      b_head_r[bused_r[3:0]] <= LINK_NONE;
    end
    if (b_upd_e) begin
      b_arr_r[work_r.bi]  <= b_arr_w;
      b_head_r[work_r.bi] <= b_head_w;
      b_tail_r[work_r.bi] <= b_tail_w;
      b_time_r[work_r.bi] <= b_time_w;
    end
  end

  // mutex and condition memories
  always_ff @(posedge clk) begin
    if (mwe) begin
      mtab[mwa] <= mwd;
    end
    mrd_r <= mtab[mrd_addr];
  end

  always_ff @(posedge clk) begin
    if (cwe) begin
      ctab[cwa] <= cwd;
    end
    crd_r <= ctab[crd_addr];
  end

  assign out_valid       = out_valid_r;
  assign out_dest_core   = out_dest_r;
  assign out_reply_kind  = out_kind_r;
  assign out_reply_value = out_value_r;
  assign out_reply_time  = out_time_r;
  assign out_last        = out_last_r;
  assign b_stat.idle     = (state_r == S_IDLE);

endmodule

>>> src/mutex_cond_barrier_sync_engine.sv
// ---------------------------------------------------------------------------
// mutex_cond_barrier_sync_engine
// Hardware lock, condition variable and barrier unit.
// ---------------------------------------------------------------------------
// Usage:
//  - in_* carries one request beat (operation, requester, time stamp and
//    mutex, condition or barrier index / size); out_* carries reply beats
//    to cores, out_last marks the final reply of a request.
//  - a request may produce no reply (lock, cond wait or barrier wait
//    that grants or releases nothing); requests land in a 4-entry queue;
//    the executor takes one at a time. A plain request takes a table read,
//    then an update, plus S_SECOND per extra reply; a signal or broadcast
//    reads, then updates each woken waiter's mutex row (S_WRD, S_WAKE) on
//    the single mutex read port; barriers release one core per cycle if
//    not stalled. With nothing queued, first reply: queue, S_IDLE, S_EXEC.
//  - reset empties the queue, clears the allocation counts and the waiting
//    flags; tables need no clearing as rows are set when allocated.
//  - when the receiver stalls, the reply register holds and the executor
//    waits; the queue keeps taking requests until it fills.
// ---------------------------------------------------------------------------
`include "mutex_cond_barrier_sync_engine_macros.svh"

module mutex_cond_barrier_sync_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_operation,
  input  logic [4:0]  in_requester,
  input  logic [63:0] in_request_time,
  input  logic [5:0]  in_mutex_index,
  input  logic [5:0]  in_cond_index,
  input  logic [3:0]  in_barrier_index,
  input  logic [5:0]  in_barrier_size,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  out_dest_core,
  output logic [2:0]  out_reply_kind,
  output logic [5:0]  out_reply_value,
  output logic [63:0] out_reply_time,
  output logic        out_last
);
  import mcbse_pkg::*;

  item_t        push_item, pop_item;
  logic         q_push, q_pop;
  q_status_t    q_stat;
  back_status_t b_stat;

  // request intake
  mcbse_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_requester     (in_requester),
    .in_request_time  (in_request_time),
    .in_mutex_index   (in_mutex_index),
    .in_cond_index    (in_cond_index),
    .in_barrier_index (in_barrier_index),
    .in_barrier_size  (in_barrier_size),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_item           (push_item)
  );

  // decoupling queue
  mcbse_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (push_item),
    .pop   (q_pop),
    .dout  (pop_item),
    .stat  (q_stat)
  );

  // executor
  mcbse_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_item          (pop_item),
    .q_stat          (q_stat),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dest_core   (out_dest_core),
    .out_reply_kind  (out_reply_kind),
    .out_reply_value (out_reply_value),
    .out_reply_time  (out_reply_time),
    .out_last        (out_last),
    .b_stat          (b_stat)
  );

  // checks
  `MCBSE_ASSERT_IMP(a_err_last, clk, rst_n, out_valid && (out_reply_kind == K_ERROR), out_last)
  `MCBSE_ASSERT_IMP(a_val_zero, clk, rst_n, out_valid && (out_reply_kind != K_INDEX), out_reply_value == 6'd0)
  `MCBSE_ASSERT_NXT(a_pickup, clk, rst_n, !q_stat.empty && b_stat.idle, !b_stat.idle)
  `MCBSE_ASSERT_IMP(a_no_overfill, clk, rst_n, q_push, !q_stat.full)

endmodule

>>> test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the lock, condition and barrier engine. Requests
// are built up front against an in-bench copy of the sync tables, so each
// request carries the replies it will cause; those replies become due when
// the request beat is taken and are matched in order against the reply port.
// ---------------------------------------------------------------------------
module tb_top;
  import mcbse_pkg::*;

  // bad operation codes outside the defined set
  localparam logic [3:0] OP_BAD_LO = 4'd9;
  localparam logic [3:0] OP_BAD_HI = 4'd15;

  // all waiter queues live in one array: mutexes, then conditions, then barriers
  localparam int QB_MUTEX = 0;
  localparam int QB_COND  = MAX_MUTEXES;
  localparam int QB_BAR   = MAX_MUTEXES + MAX_CONDS;
  localparam int NQ       = QB_BAR + MAX_BARRIERS;

  localparam int IDLE_LIMIT  = 4000;
  localparam int HOLD_LEN    = 500;
  localparam int HOLD_AT     = 60;
  localparam int RAND_ITEMS  = 112;
  localparam int HOT_MUTEXES = 8;
  localparam int HOT_CONDS   = 4;

  typedef struct {
    logic [3:0]  op;
    logic [4:0]  req;
    logic [63:0] stamp;
    logic [5:0]  mi;
    logic [5:0]  ci;
    logic [3:0]  bi;
    logic [5:0]  bsize;
  } sync_req_t;

  typedef struct {
    logic [4:0]  dest;
    logic [2:0]  kind;
    logic [5:0]  val;
    logic [63:0] stamp;
    logic        last;
  } sync_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_operation = '0;
  logic [4:0]  in_requester = '0;
  logic [63:0] in_request_time = '0;
  logic [5:0]  in_mutex_index = '0;
  logic [5:0]  in_cond_index = '0;
  logic [3:0]  in_barrier_index = '0;
  logic [5:0]  in_barrier_size = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_dest_core;
  logic [2:0]  out_reply_kind;
  logic [5:0]  out_reply_value;
  logic [63:0] out_reply_time;
  logic        out_last;

  mutex_cond_barrier_sync_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_operation(in_operation), .in_requester(in_requester),
    .in_request_time(in_request_time), .in_mutex_index(in_mutex_index),
    .in_cond_index(in_cond_index), .in_barrier_index(in_barrier_index),
    .in_barrier_size(in_barrier_size),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_dest_core(out_dest_core), .out_reply_kind(out_reply_kind),
    .out_reply_value(out_reply_value), .out_reply_time(out_reply_time),
    .out_last(out_last)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // shadow sync tables
  logic [5:0]  holder [MAX_MUTEXES];
  logic [5:0]  qh [NQ];
  logic [4:0]  qt [NQ];
  logic [5:0]  link [NUM_CORES];
  logic [5:0]  relock [NUM_CORES];
  logic [5:0]  b_need [MAX_BARRIERS];
  logic [5:0]  b_arr [MAX_BARRIERS];
  logic [63:0] b_late [MAX_BARRIERS];
  bit          waiting [NUM_CORES];
  int          n_mutex, n_cond, n_barrier;

  sync_reply_t step_replies[$];
  sync_req_t   request_q[$];
  int          reply_count_q[$];
  sync_reply_t pend_replies[$];
  sync_reply_t due_replies[$];
  int          errors = 0;

  function automatic void emit(logic [4:0] d, logic [2:0] k, logic [5:0] v, logic [63:0] t);
    sync_reply_t r;
    r.dest = d; r.kind = k; r.val = v; r.stamp = t; r.last = 1'b0;
    step_replies.insert(step_replies.size(), r);
  endfunction

  function automatic void enq(int q, logic [4:0] c);
    link[c] = LINK_NONE;
    if (qh[q] == LINK_NONE) qh[q] = {1'b0, c};
    else link[qt[q]] = {1'b0, c};
    qt[q] = c;
    waiting[c] = 1'b1;
  endfunction

  function automatic logic [5:0] deq(int q);
    logic [5:0] c;
    c = qh[q];
    if (c >= NUM_CORES) return LINK_NONE;
    qh[q] = link[c[4:0]];
    if (qh[q] >= NUM_CORES) qh[q] = LINK_NONE;
    return c;
  endfunction

  // mutex goes to the next queued locker, if any
  function automatic void free_mutex(logic [5:0] m, logic [63:0] t);
    logic [5:0] c;
    c = deq(QB_MUTEX + m);
    if (c == LINK_NONE) holder[m] = HOLDER_NONE;
    else begin
      holder[m] = c;
      waiting[c[4:0]] = 1'b0;
      emit(c[4:0], K_GRANT, '0, t);
    end
  endfunction

  // woken condition waiter retakes its mutex or queues on it
  function automatic void wake(logic [5:0] c, logic [63:0] t);
    logic [5:0] m;
    m = relock[c[4:0]];
    waiting[c[4:0]] = 1'b0;
    if (holder[m] == HOLDER_NONE) begin
      holder[m] = c;
      emit(c[4:0], K_GRANT, '0, t);
    end else enq(QB_MUTEX + m, c[4:0]);
  endfunction

  function automatic void sync_reset();
    foreach (holder[i]) holder[i] = HOLDER_NONE;
    foreach (qh[i]) begin qh[i] = LINK_NONE; qt[i] = '0; end
    foreach (link[i]) begin link[i] = '0; relock[i] = '0; waiting[i] = 1'b0; end
    foreach (b_need[i]) begin b_need[i] = '0; b_arr[i] = '0; b_late[i] = '0; end
    n_mutex = 0; n_cond = 0; n_barrier = 0;
  endfunction

  // replies of one request, applied to the shadow tables
  function automatic void sync_predict(sync_req_t r);
    logic [5:0] c;
    bit err;
    int s;
    err = 1'b0;
    step_replies.delete();
    if (waiting[r.req] || r.op > OP_BARRIER_WAIT) err = 1'b1;
    else case (r.op)
      OP_MUTEX_INIT: begin
        if (n_mutex >= MAX_MUTEXES) err = 1'b1;
        else begin
          holder[n_mutex] = HOLDER_NONE;
          qh[QB_MUTEX + n_mutex] = LINK_NONE;
          emit(r.req, K_INDEX, n_mutex[5:0], r.stamp);
          n_mutex++;
        end
      end
      OP_LOCK: begin
        if (r.mi >= n_mutex) err = 1'b1;
        else if (holder[r.mi] == HOLDER_NONE) begin
          holder[r.mi] = {1'b0, r.req};
          emit(r.req, K_GRANT, '0, r.stamp);
        end else enq(QB_MUTEX + r.mi, r.req);
      end
      OP_UNLOCK: begin
        if (r.mi >= n_mutex || holder[r.mi] != {1'b0, r.req}) err = 1'b1;
        else begin
          free_mutex(r.mi, r.stamp);
          emit(r.req, K_UNLOCK, '0, r.stamp);
        end
      end
      OP_COND_INIT: begin
        if (n_cond >= MAX_CONDS) err = 1'b1;
        else begin
          qh[QB_COND + n_cond] = LINK_NONE;
          emit(r.req, K_INDEX, n_cond[5:0], r.stamp);
          n_cond++;
        end
      end
      OP_COND_WAIT: begin
        if (r.mi >= n_mutex || r.ci >= n_cond || holder[r.mi] != {1'b0, r.req}) err = 1'b1;
        else begin
          relock[r.req] = r.mi;
          enq(QB_COND + r.ci, r.req);
          free_mutex(r.mi, r.stamp);
        end
      end
      OP_SIGNAL: begin
        if (r.ci >= n_cond) err = 1'b1;
        else begin
          c = deq(QB_COND + r.ci);
          if (c != LINK_NONE) wake(c, r.stamp);
          emit(r.req, K_SIGNAL, '0, r.stamp);
        end
      end
      OP_BROADCAST: begin
        if (r.ci >= n_cond) err = 1'b1;
        else begin
          for (s = 0; s < NUM_CORES; s++) begin
            c = deq(QB_COND + r.ci);
            if (c == LINK_NONE) break;
            wake(c, r.stamp);
          end
          qh[QB_COND + r.ci] = LINK_NONE;
          emit(r.req, K_BCAST, '0, r.stamp);
        end
      end
      OP_BARRIER_INIT: begin
        if (n_barrier >= MAX_BARRIERS) err = 1'b1;
        else begin
          b_need[n_barrier] = r.bsize;
          b_arr[n_barrier] = '0;
          qh[QB_BAR + n_barrier] = LINK_NONE;
          emit(r.req, K_INDEX, n_barrier[5:0], r.stamp);
          n_barrier++;
        end
      end
      default: begin
        if (r.bi >= n_barrier || int'(b_arr[r.bi]) + 1 > int'(b_need[r.bi])) err = 1'b1;
        else begin
          enq(QB_BAR + r.bi, r.req);
          b_arr[r.bi] = b_arr[r.bi] + 1'b1;
          if (b_arr[r.bi] == 6'd1 || r.stamp > b_late[r.bi]) b_late[r.bi] = r.stamp;
          if (b_arr[r.bi] == b_need[r.bi]) begin
            for (s = 0; s < NUM_CORES; s++) begin
              c = deq(QB_BAR + r.bi);
              if (c == LINK_NONE) break;
              waiting[c[4:0]] = 1'b0;
              emit(c[4:0], K_RELEASE, '0, b_late[r.bi]);
            end
            qh[QB_BAR + r.bi] = LINK_NONE;
            b_arr[r.bi] = '0;
          end
        end
      end
    endcase
    if (err) begin
      step_replies.delete();
      emit(r.req, K_ERROR, '0, r.stamp);
    end
    if (step_replies.size() > 0) step_replies[step_replies.size() - 1].last = 1'b1;
  endfunction

  // queue one request along with the replies it will cause
  task automatic add_request(logic [3:0] op, logic [4:0] req, logic [63:0] t,
                             logic [5:0] mi, logic [5:0] ci, logic [3:0] bi,
                             logic [5:0] bs);
    sync_req_t r;
    r.op = op; r.req = req; r.stamp = t; r.mi = mi; r.ci = ci; r.bi = bi; r.bsize = bs;
    sync_predict(r);
    request_q.insert(request_q.size(), r);
    reply_count_q.insert(reply_count_q.size(), step_replies.size());
    foreach (step_replies[i]) pend_replies.insert(pend_replies.size(), step_replies[i]);
  endtask

  function automatic logic [63:0] rand_stamp();
    return {$urandom, $urandom};
  endfunction

  // a core not sitting in any queue, if one turns up
  function automatic logic [4:0] free_core();
    logic [4:0] c;
    for (int k = 0; k < 64; k++) begin
      c = 5'($urandom_range(0, NUM_CORES - 1));
      if (!waiting[c]) return c;
    end
    return c;
  endfunction

  // a mutex among the busy ones whose holder can act, else a random one
  function automatic logic [5:0] held_mutex();
    logic [5:0] m;
    for (int k = 0; k < 32; k++) begin
      m = 6'($urandom_range(1, HOT_MUTEXES));
      if (holder[m] < NUM_CORES && !waiting[holder[m][4:0]]) return m;
    end
    return m;
  endfunction

  task automatic build_stimulus();
    logic [5:0] m;
    logic [3:0] b;
    int p;
    sync_reset();
    // directed: errors on empty tables, first allocations, lock hand-off
    add_request(OP_BAD_LO, 5'd0, 64'd0, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_BAD_HI, 5'd31, '1, '1, '1, '1, '1);
    add_request(OP_LOCK, 5'd1, 64'd5, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_MUTEX_INIT, 5'd31, 64'd6, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_COND_INIT, 5'd0, 64'd7, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_BARRIER_INIT, 5'd2, 64'd8, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_BARRIER_WAIT, 5'd3, 64'd9, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_BARRIER_WAIT, 5'd3, 64'd9, 6'd0, 6'd0, 4'd15, 6'd0);
    add_request(OP_COND_WAIT, 5'd4, 64'd10, 6'd0, 6'd5, 4'd0, 6'd0);
    add_request(OP_SIGNAL, 5'd4, 64'd11, 6'd0, 6'd63, 4'd0, 6'd0);
    add_request(OP_BROADCAST, 5'd4, 64'd12, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_SIGNAL, 5'd4, 64'd13, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_LOCK, 5'd2, 64'd14, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_UNLOCK, 5'd4, 64'd15, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_COND_WAIT, 5'd4, 64'd16, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_COND_WAIT, 5'd2, 64'd17, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_SIGNAL, 5'd5, 64'd18, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_LOCK, 5'd6, 64'd19, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_LOCK, 5'd6, 64'd20, 6'd0, 6'd0, 4'd0, 6'd0);
    add_request(OP_UNLOCK, 5'd2, 64'd21, 6'd0, 6'd0, 4'd0, 6'd0);
    // owner locks again: core 6 queues behind itself for good
    add_request(OP_LOCK, 5'd6, 64'd22, 6'd0, 6'd0, 4'd0, 6'd0);
    // the hot mutexes and conditions, and every barrier plus one past the end
    for (int k = 1; k <= HOT_MUTEXES; k++)
      add_request(OP_MUTEX_INIT, free_core(), rand_stamp(), '0, '0, '0, '0);
    for (int k = 1; k < HOT_CONDS; k++)
      add_request(OP_COND_INIT, free_core(), rand_stamp(), '0, '0, '0, '0);
    for (int k = 1; k <= MAX_BARRIERS; k++)
      add_request(OP_BARRIER_INIT, free_core(), rand_stamp(), '0, '0, '0,
                  (k == 1) ? 6'd32 : (k == 2) ? 6'd63 : 6'(k % 5 + 1));
    // random traffic, mostly well-formed on a few hot mutexes and conditions
    for (int k = 0; k < RAND_ITEMS; k++) begin
      p = $urandom_range(0, 99);
      if (p < 22) begin
        add_request(OP_LOCK, free_core(), rand_stamp(), 6'($urandom_range(1, HOT_MUTEXES)),
                    '0, '0, '0);
      end else if (p < 42) begin
        m = held_mutex();
        add_request(OP_UNLOCK, holder[m][4:0], rand_stamp(), m, '0, '0, '0);
      end else if (p < 54) begin
        m = held_mutex();
        add_request(OP_COND_WAIT, holder[m][4:0], rand_stamp(), m,
                    6'($urandom_range(0, HOT_CONDS - 1)), '0, '0);
      end else if (p < 64) begin
        add_request(OP_SIGNAL, free_core(), rand_stamp(), '0,
                    6'($urandom_range(0, HOT_CONDS - 1)), '0, '0);
      end else if (p < 70) begin
        add_request(OP_BROADCAST, free_core(), rand_stamp(), '0,
                    6'($urandom_range(0, HOT_CONDS - 1)), '0, '0);
      end else if (p < 84) begin
        b = 4'($urandom_range(3, MAX_BARRIERS - 1));
        if (k > RAND_ITEMS - 40 && $urandom_range(0, 3) == 0) b = 4'd1;
        add_request(OP_BARRIER_WAIT, free_core(), rand_stamp(), '0, '0, b, '0);
      end else begin
        // noise over the whole field ranges
        add_request(4'($urandom_range(0, 15)), 5'($urandom), rand_stamp(), 6'($urandom),
                    6'($urandom), 4'($urandom), 6'($urandom));
      end
    end
  endtask

  // request driver
  int idle_gap = 0;
  int sent = 0;
  bit in_take;
  sync_req_t cur;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      in_take = in_valid && !in_stall;
      if (in_take) begin
        for (int n = reply_count_q.pop_front(); n > 0; n--)
          due_replies.insert(due_replies.size(), pend_replies.pop_front());
        sent++;
      end
      if (!in_valid || in_take) begin
        if (idle_gap > 0) begin
          idle_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur = request_q.pop_front();
          in_operation <= cur.op;
          in_requester <= cur.req;
          in_request_time <= cur.stamp;
          in_mutex_index <= cur.mi;
          in_cond_index <= cur.ci;
          in_barrier_index <= cur.bi;
          in_barrier_size <= cur.bsize;
          in_valid <= 1'b1;
          // runs of back-to-back beats between stretches of random gaps
          idle_gap = ((sent / 40) % 2 == 1) ? 0 : $urandom_range(0, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // reply monitor and receiver stall
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int beats = 0;
  sync_reply_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_replies.size() == 0) begin
          report("unexpected beat dest", out_dest_core, 0);
        end else begin
          want = due_replies.pop_front();
          if (out_dest_core !== want.dest) report("dest_core", out_dest_core, want.dest);
          if (out_reply_kind !== want.kind) report("reply_kind", out_reply_kind, want.kind);
          if (out_reply_value !== want.val) report("reply_value", out_reply_value, want.val);
          if (out_reply_time !== want.stamp) report("reply_time", out_reply_time, want.stamp);
          if (out_last !== want.last) report("last", out_last, want.last);
        end
        beats++;
        stall_left = ((beats / 30) % 3 == 2) ? 0 : $urandom_range(0, 18);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  // one long hold-off so the request queue backs up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (rst_n && !hold_done && beats >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end
  end

  // watchdog on cycles with no beat on either side
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // reset, stimulus and end of run
  initial begin
    build_stimulus();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk);
    while (request_q.size() > 0 || in_valid || due_replies.size() > 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && due_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/mcbse_pkg.sv
src/mcbse_front.sv
src/mcbse_queue.sv
src/mcbse_back.sv
src/mutex_cond_barrier_sync_engine.sv
test/tb_top.sv
